@@ design/onewire_bus_master_defines.svh @@
// Assertion macros shared by the 1-Wire master RTL.
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/owm_pkg.sv @@
package owm_pkg;

   // Widths
   localparam int unsigned TICK_W = 10;
   localparam int unsigned PE_W   = 16;
   localparam int unsigned CSR_W  = 16;
   localparam int unsigned CSR_IW = 3;

   typedef logic [TICK_W-1:0] tick_type;

   localparam tick_type TICK_ONE = {{(TICK_W-1){1'b0}}, 1'b1};

   // Request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_RESET = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // Register indexes
   localparam logic [CSR_IW-1:0] CSR_RESET_LOW      = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_WRITE_ONE_LOW  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_WRITE_ZERO_LOW = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_SLOT           = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_RECOVERY       = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_READ_INIT      = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_READ_SAMPLE    = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_PRESENCE_TMO   = 3'd7;

   // Bus phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RREL,    // release before reset pulse
      PH_RLOW,    // reset pulse low
      PH_WLOWP,   // waiting for presence low
      PH_WHIGHP,  // waiting for line high after presence
      PH_PAD,     // rest of reset time
      PH_WRLOW,   // write slot low
      PH_WRREL,   // write slot released
      PH_RDLOW,   // read slot opening low
      PH_RDWAIT,  // wait until sample point
      PH_RDTAIL   // sample and finish read slot
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       line_level;
   } req_item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       fail;
      logic [7:0] rx_byte;
   } rsp_item_type;

   typedef struct packed {
      logic [9:0]      reset_low_ticks;
      logic [7:0]      write_one_low_ticks;
      logic [7:0]      write_zero_low_ticks;
      logic [7:0]      slot_ticks;
      logic [7:0]      recovery_ticks;
      logic [7:0]      read_init_ticks;
      logic [7:0]      read_sample_ticks;
      logic [PE_W-1:0] presence_timeout_ticks;
   } cfg_type;

   localparam cfg_type CFG_DEFAULT = '{
      reset_low_ticks:        10'd480,
      write_one_low_ticks:    8'd6,
      write_zero_low_ticks:   8'd60,
      slot_ticks:             8'd65,
      recovery_ticks:         8'd5,
      read_init_ticks:        8'd6,
      read_sample_ticks:      8'd15,
      presence_timeout_ticks: 16'd1000
   };

   // Phase lengths derived from the registers
   typedef struct packed {
      tick_type reset_low;
      tick_type wr_low1;
      tick_type wr_low0;
      tick_type wr_rel1;
      tick_type wr_rel0;
      tick_type rd_init;
      tick_type rd_wait;
      tick_type rd_tail;
      logic     zero1;    // a one bit takes no time at all
      logic     zero0;    // a zero bit takes no time at all
   } timing_type;

   typedef struct packed {
      phase_type       phase;
      tick_type        ticks;
      logic [PE_W-1:0] pe;
      logic [2:0]      bit_index;
      logic [7:0]      shift;
   } ctl_state_type;

   localparam ctl_state_type STATE_RESET = '{
      phase:     PH_IDLE,
      ticks:     '0,
      pe:        '0,
      bit_index: '0,
      shift:     '0
   };

   typedef struct packed {
      ctl_state_type st;
      logic          done;
   } settle_type;

endpackage

@@ design/onewire_bus_master.sv @@
// 1-Wire bus master driven by a stream of one-microsecond ticks. Every accepted
// transaction is one tick carrying the sampled line level and an optional
// command (bus reset, write byte, read byte; commands arriving while busy are
// ignored), and yields exactly one result: drive_low for the line, busy, done,
// fail and the byte read. One transaction is accepted per clock cycle while
// req_ready is high; its result is registered onto rsp_data. The tick logic,
// including skipping any run of zero-length phases, sits between the state
// registers and the result register. A result register plus one skid entry
// let the input keep flowing while a result is stalled; once the skid entry is
// full, req_ready drops until it drains. The user must set timings through the
// csr_ port while the master is idle; the block itself does not enforce this.
`include "onewire_bus_master_defines.svh"

module onewire_bus_master #(
   parameter int unsigned RELEASE_TICKS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  owm_pkg::req_item_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output owm_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_we,
   input  logic [owm_pkg::CSR_IW-1:0]          csr_index,
   input  logic [owm_pkg::CSR_W-1:0]           csr_wdata
);

   localparam owm_pkg::tick_type RELEASE_LEN = RELEASE_TICKS[owm_pkg::TICK_W-1:0];

   owm_pkg::cfg_type       cfg_ff, cfg_in;
   owm_pkg::ctl_state_type state_ff, state_in;
   logic [1:0]             op_kind_ff, op_kind_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   owm_pkg::rsp_item_type  rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   owm_pkg::rsp_item_type  skid_data_ff, skid_data_in;

   owm_pkg::timing_type    tm;
   owm_pkg::ctl_state_type s_start, s_tick;
   owm_pkg::settle_type    first, second;
   owm_pkg::phase_type     tick_phase;
   owm_pkg::rsp_item_type  result;
   logic                   accept, start, pres_fail, finish, out_free;
   logic [1:0]             op_kind_eff;
   logic [8:0]             slot_rec, tail9;

   // Leave every phase whose time is used up, skipping zero-length ones
   function automatic owm_pkg::settle_type settle(input owm_pkg::ctl_state_type s,
                                                  input owm_pkg::timing_type    t);
      owm_pkg::settle_type r;
      owm_pkg::tick_type   wr_low;
      owm_pkg::tick_type   wr_rel;
      owm_pkg::tick_type   pad;
      logic                bit_end;
      logic                found;
      logic [2:0]          skip;
      logic [7:0]          rest;
      r.st    = s;
      r.done  = 1'b0;
      bit_end = 1'b0;
      found   = 1'b0;
      skip    = '0;
      wr_low  = s.shift[0] ? t.wr_low1 : t.wr_low0;
      wr_rel  = s.shift[0] ? t.wr_rel1 : t.wr_rel0;
      pad     = (s.pe >= {{(owm_pkg::PE_W-owm_pkg::TICK_W){1'b0}}, t.reset_low}) ? '0 :
                t.reset_low - s.pe[owm_pkg::TICK_W-1:0];
      case (s.phase)
         owm_pkg::PH_RREL: begin
            if (s.ticks >= RELEASE_LEN) begin
               r.st.ticks = '0;
               if (t.reset_low == '0) begin
                  r.st.phase = owm_pkg::PH_WLOWP;
                  r.st.pe    = '0;
               end else begin
                  r.st.phase = owm_pkg::PH_RLOW;
               end
            end
         end
         owm_pkg::PH_RLOW: begin
            if (s.ticks >= t.reset_low) begin
               r.st.ticks = '0;
               r.st.phase = owm_pkg::PH_WLOWP;
               r.st.pe    = '0;
            end
         end
         owm_pkg::PH_PAD: begin
            if (s.ticks >= pad) begin
               r.st.ticks = '0;
               r.st.phase = owm_pkg::PH_IDLE;
               r.done     = 1'b1;
            end
         end
         owm_pkg::PH_WRLOW: begin
            if (s.ticks >= wr_low) begin
               r.st.ticks = '0;
               if (wr_rel == '0) begin
                  bit_end = 1'b1;
               end else begin
                  r.st.phase = owm_pkg::PH_WRREL;
               end
            end
         end
         owm_pkg::PH_WRREL: begin
            if (s.ticks >= wr_rel) begin
               r.st.ticks = '0;
               bit_end    = 1'b1;
            end
         end
         owm_pkg::PH_RDLOW: begin
            if (s.ticks >= t.rd_init) begin
               r.st.ticks = '0;
               r.st.phase = (t.rd_wait == '0) ? owm_pkg::PH_RDTAIL : owm_pkg::PH_RDWAIT;
            end
         end
         owm_pkg::PH_RDWAIT: begin
            if (s.ticks >= t.rd_wait) begin
               r.st.ticks = '0;
               r.st.phase = owm_pkg::PH_RDTAIL;
            end
         end
         owm_pkg::PH_RDTAIL: begin
            if (s.ticks >= t.rd_tail) begin
               r.st.ticks     = '0;
               r.st.bit_index = s.bit_index + 3'd1;
               if (s.bit_index == 3'd7) begin
                  r.st.phase = owm_pkg::PH_IDLE;
                  r.done     = 1'b1;
               end else if (t.rd_init != '0) begin
                  r.st.phase = owm_pkg::PH_RDLOW;
               end else begin
                  r.st.phase = (t.rd_wait == '0) ? owm_pkg::PH_RDTAIL : owm_pkg::PH_RDWAIT;
               end
            end
         end
         default: begin
         end
      endcase

      // Write bit finished: jump to the next bit that takes any time
      if (bit_end) begin
         for (int j = 7; j >= 1; j--) begin
            if ((j + int'(s.bit_index) <= 7) && !(s.shift[j] ? t.zero1 : t.zero0)) begin
               found = 1'b1;
               skip  = 3'(j);
            end
         end
         if (found) begin
            rest           = s.shift >> skip;
            r.st.shift     = rest;
            r.st.bit_index = s.bit_index + skip;
            r.st.phase     = ((rest[0] ? t.wr_low1 : t.wr_low0) == '0) ?
                             owm_pkg::PH_WRREL : owm_pkg::PH_WRLOW;
         end else begin
            r.st.phase     = owm_pkg::PH_IDLE;
            r.st.bit_index = '0;
            r.done         = 1'b1;
         end
      end
      return r;
   endfunction

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            owm_pkg::CSR_RESET_LOW:      cfg_in.reset_low_ticks        = csr_wdata[9:0];
            owm_pkg::CSR_WRITE_ONE_LOW:  cfg_in.write_one_low_ticks    = csr_wdata[7:0];
            owm_pkg::CSR_WRITE_ZERO_LOW: cfg_in.write_zero_low_ticks   = csr_wdata[7:0];
            owm_pkg::CSR_SLOT:           cfg_in.slot_ticks             = csr_wdata[7:0];
            owm_pkg::CSR_RECOVERY:       cfg_in.recovery_ticks         = csr_wdata[7:0];
            owm_pkg::CSR_READ_INIT:      cfg_in.read_init_ticks        = csr_wdata[7:0];
            owm_pkg::CSR_READ_SAMPLE:    cfg_in.read_sample_ticks      = csr_wdata[7:0];
            owm_pkg::CSR_PRESENCE_TMO:   cfg_in.presence_timeout_ticks = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Phase lengths, negative ones clamped to zero (the read tail to one)
   always_comb begin
      slot_rec   = {1'b0, cfg_ff.slot_ticks} + {1'b0, cfg_ff.recovery_ticks};
      tm.reset_low = cfg_ff.reset_low_ticks;
      tm.wr_low1 = {2'b00, cfg_ff.write_one_low_ticks};
      tm.wr_low0 = {2'b00, cfg_ff.write_zero_low_ticks};
      tm.wr_rel1 = (slot_rec > {1'b0, cfg_ff.write_one_low_ticks}) ?
                   {1'b0, slot_rec - {1'b0, cfg_ff.write_one_low_ticks}} : '0;
      tm.wr_rel0 = {2'b00, cfg_ff.recovery_ticks};
      tm.rd_init = {2'b00, cfg_ff.read_init_ticks};
      tm.rd_wait = (cfg_ff.read_sample_ticks > cfg_ff.read_init_ticks) ?
                   {2'b00, cfg_ff.read_sample_ticks - cfg_ff.read_init_ticks} : '0;
      tail9      = (slot_rec > {1'b0, cfg_ff.read_sample_ticks}) ?
                   slot_rec - {1'b0, cfg_ff.read_sample_ticks} : '0;
      tm.rd_tail = (tail9 == '0) ? owm_pkg::TICK_ONE : {1'b0, tail9};
      tm.zero1   = (cfg_ff.write_one_low_ticks == '0) && (tm.wr_rel1 == '0);
      tm.zero0   = (cfg_ff.write_zero_low_ticks == '0) && (cfg_ff.recovery_ticks == '0);
   end

   // Next state: command start, settle, one tick, settle again
   always_comb begin
      accept  = req_valid && req_ready;
      start   = accept && (state_ff.phase == owm_pkg::PH_IDLE) &&
                (req_data.req_type != owm_pkg::REQ_TICK);
      s_start = state_ff;
      if (start) begin
         s_start.ticks     = '0;
         s_start.pe        = '0;
         s_start.bit_index = '0;
         s_start.shift     = (req_data.req_type == owm_pkg::REQ_WRITE) ? req_data.tx_byte : '0;
         case (req_data.req_type)
            owm_pkg::REQ_RESET: s_start.phase = owm_pkg::PH_RREL;
            owm_pkg::REQ_WRITE: s_start.phase = owm_pkg::PH_WRLOW;
            default:            s_start.phase = owm_pkg::PH_RDLOW;
         endcase
      end
      first      = settle(s_start, tm);
      tick_phase = first.st.phase;
      s_tick     = first.st;
      pres_fail  = 1'b0;
      case (s_tick.phase)
         owm_pkg::PH_IDLE: begin
         end
         owm_pkg::PH_WLOWP: begin
            if (!req_data.line_level) begin
               s_tick.phase = owm_pkg::PH_WHIGHP;
               s_tick.pe    = '0;
            end else if (s_tick.pe >= cfg_ff.presence_timeout_ticks) begin
               s_tick.phase = owm_pkg::PH_IDLE;
               pres_fail    = 1'b1;
            end else begin
               s_tick.pe = s_tick.pe + 16'd1;
            end
         end
         owm_pkg::PH_WHIGHP: begin
            if (req_data.line_level) begin
               s_tick.phase = owm_pkg::PH_PAD;
               s_tick.ticks = '0;
            end else if (s_tick.pe >= cfg_ff.presence_timeout_ticks) begin
               s_tick.phase = owm_pkg::PH_IDLE;
               pres_fail    = 1'b1;
            end else begin
               s_tick.pe = s_tick.pe + 16'd1;
            end
         end
         default: begin
            // sample once at the start of the read tail
            if ((s_tick.phase == owm_pkg::PH_RDTAIL) && (s_tick.ticks == '0)) begin
               s_tick.shift = {req_data.line_level, s_tick.shift[7:1]};
            end
            s_tick.ticks = s_tick.ticks + owm_pkg::TICK_ONE;
         end
      endcase
      second      = settle(s_tick, tm);
      finish      = first.done || pres_fail || second.done;
      state_in    = accept ? second.st : state_ff;
      op_kind_eff = start ? req_data.req_type : op_kind_ff;
      op_kind_in  = op_kind_eff;
   end

   // Result item
   always_comb begin
      result.drive_low = tick_phase inside {owm_pkg::PH_RLOW, owm_pkg::PH_WRLOW,
                                            owm_pkg::PH_RDLOW};
      result.busy_res  = start || (state_ff.phase != owm_pkg::PH_IDLE);
      result.done_res  = finish;
      result.fail      = pres_fail;
      result.rx_byte   = (finish && !pres_fail && (op_kind_eff == owm_pkg::REQ_READ)) ?
                         second.st.shift : '0;
   end

   // Output register with one skid entry
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   assign req_ready = !skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= owm_pkg::CFG_DEFAULT;
         state_ff      <= owm_pkg::STATE_RESET;
         op_kind_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         op_kind_ff    <= op_kind_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   `OWM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid entry full while output register empty")
   `OWM_ASSERT_NEXT(a_idle_after_done, clock, reset, accept && finish, state_ff.phase == owm_pkg::PH_IDLE, "master not idle after finishing")
   `OWM_ASSERT_NOW(a_fail_with_done, clock, reset, rsp_valid_ff && rsp_data_ff.fail, rsp_data_ff.done_res && (rsp_data_ff.rx_byte == '0), "fail without done or with data")
   `OWM_ASSERT_NOW(a_drive_when_busy, clock, reset, rsp_valid_ff && rsp_data_ff.drive_low, rsp_data_ff.busy_res, "line driven while not busy")

endmodule

@@ tb/sv/onewire_bus_master_tb.sv @@
module onewire_bus_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RELEASE_TICKS   = 10;
   localparam int unsigned WATCHDOG_LIMIT  = 5000;
   localparam int unsigned HOLDOFF_CYCLES  = 300;
   localparam int unsigned TICKS_PER_PHASE = 60;
   localparam int unsigned RANDOM_PHASES   = 4;

   // How the emulated slave misbehaves during a bus reset
   typedef enum int unsigned {
      FAULT_NONE,
      FAULT_NO_PRESENCE,   // line never goes low after the reset pulse
      FAULT_STUCK_LOW      // line never comes back high after presence
   } fault_type;

   // Tick-accurate copy of the master plus the queue of outcomes still due
   class owm_scoreboard;
      owm_pkg::cfg_type       cfg = owm_pkg::CFG_DEFAULT;
      owm_pkg::phase_type     phase = owm_pkg::PH_IDLE;
      logic [15:0]            tick_count = '0;
      logic [15:0]            presence_elapsed = '0;
      logic [2:0]             bit_index = '0;
      logic [7:0]             shift_byte = '0;
      logic [1:0]             op_kind = '0;
      owm_pkg::rsp_item_type  line_outcomes[$];
      int unsigned            mismatches = 0;
      int unsigned            ticks_noted = 0;
      int unsigned            dones = 0;
      int unsigned            timeouts = 0;

      static function int unsigned sat_sub(int unsigned a, int unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      function void write_reg(logic [owm_pkg::CSR_IW-1:0] idx,
                              logic [owm_pkg::CSR_W-1:0] data);
         case (idx)
            owm_pkg::CSR_RESET_LOW:      cfg.reset_low_ticks        = data[9:0];
            owm_pkg::CSR_WRITE_ONE_LOW:  cfg.write_one_low_ticks    = data[7:0];
            owm_pkg::CSR_WRITE_ZERO_LOW: cfg.write_zero_low_ticks   = data[7:0];
            owm_pkg::CSR_SLOT:           cfg.slot_ticks             = data[7:0];
            owm_pkg::CSR_RECOVERY:       cfg.recovery_ticks         = data[7:0];
            owm_pkg::CSR_READ_INIT:      cfg.read_init_ticks        = data[7:0];
            owm_pkg::CSR_READ_SAMPLE:    cfg.read_sample_ticks      = data[7:0];
            owm_pkg::CSR_PRESENCE_TMO:   cfg.presence_timeout_ticks = data;
            default: ;
         endcase
      endfunction

      // Leave every timed phase whose length is used up; 1 when the operation ends
      function bit settle();
         int unsigned span;
         int unsigned slot_rec;
         bit          one;
         forever begin
            one      = shift_byte[0];
            slot_rec = cfg.slot_ticks;
            slot_rec += cfg.recovery_ticks;
            case (phase)
               owm_pkg::PH_RREL:   span = RELEASE_TICKS;
               owm_pkg::PH_RLOW:   span = cfg.reset_low_ticks;
               owm_pkg::PH_PAD:    span = sat_sub(cfg.reset_low_ticks, presence_elapsed);
               owm_pkg::PH_WRLOW:  span = one ? cfg.write_one_low_ticks
                                              : cfg.write_zero_low_ticks;
               owm_pkg::PH_WRREL:  span = one ? sat_sub(slot_rec, cfg.write_one_low_ticks)
                                              : cfg.recovery_ticks;
               owm_pkg::PH_RDLOW:  span = cfg.read_init_ticks;
               owm_pkg::PH_RDWAIT: span = sat_sub(cfg.read_sample_ticks, cfg.read_init_ticks);
               owm_pkg::PH_RDTAIL: begin
                  span = sat_sub(slot_rec, cfg.read_sample_ticks);
                  if (span == 0) span = 1;
               end
               default:   return 1'b0;  // idle and presence waits are untimed
            endcase
            if (tick_count < span) return 1'b0;
            tick_count = '0;
            case (phase)
               owm_pkg::PH_RREL: phase = owm_pkg::PH_RLOW;
               owm_pkg::PH_RLOW: begin
                  phase            = owm_pkg::PH_WLOWP;
                  presence_elapsed = '0;
               end
               owm_pkg::PH_WRLOW: phase = owm_pkg::PH_WRREL;
               owm_pkg::PH_WRREL: begin
                  shift_byte = shift_byte >> 1;
                  bit_index  = bit_index + 3'd1;
                  if (bit_index == 3'd0) begin
                     phase = owm_pkg::PH_IDLE;
                     return 1'b1;
                  end
                  phase = owm_pkg::PH_WRLOW;
               end
               owm_pkg::PH_RDLOW:  phase = owm_pkg::PH_RDWAIT;
               owm_pkg::PH_RDWAIT: phase = owm_pkg::PH_RDTAIL;
               owm_pkg::PH_RDTAIL: begin
                  bit_index = bit_index + 3'd1;
                  if (bit_index == 3'd0) begin
                     phase = owm_pkg::PH_IDLE;
                     return 1'b1;
                  end
                  phase = owm_pkg::PH_RDLOW;
               end
               default: begin  // pad finished
                  phase = owm_pkg::PH_IDLE;
                  return 1'b1;
               end
            endcase
         end
      endfunction

      // Advance one tick and queue the outcome the master must give for it
      function void note_tick(owm_pkg::req_item_type it);
         owm_pkg::rsp_item_type r;
         bit                    finished;
         r        = '0;
         finished = 1'b0;
         ticks_noted++;

         // command start, only from idle
         if (phase == owm_pkg::PH_IDLE && it.req_type != owm_pkg::REQ_TICK) begin
            op_kind          = it.req_type;
            bit_index        = '0;
            tick_count       = '0;
            presence_elapsed = '0;
            shift_byte       = (it.req_type == owm_pkg::REQ_WRITE) ? it.tx_byte : 8'h00;
            case (it.req_type)
               owm_pkg::REQ_RESET: phase = owm_pkg::PH_RREL;
               owm_pkg::REQ_WRITE: phase = owm_pkg::PH_WRLOW;
               default:            phase = owm_pkg::PH_RDLOW;
            endcase
            finished   = settle();
            r.busy_res = 1'b1;
         end

         if (!finished && phase != owm_pkg::PH_IDLE) begin
            r.busy_res = 1'b1;
            case (phase)
               owm_pkg::PH_WLOWP: begin
                  if (!it.line_level) begin
                     phase            = owm_pkg::PH_WHIGHP;
                     presence_elapsed = '0;
                  end else if (presence_elapsed >= cfg.presence_timeout_ticks) begin
                     phase    = owm_pkg::PH_IDLE;
                     finished = 1'b1;
                     r.fail   = 1'b1;
                  end else begin
                     presence_elapsed++;
                  end
               end
               owm_pkg::PH_WHIGHP: begin
                  if (it.line_level) begin
                     phase      = owm_pkg::PH_PAD;
                     tick_count = '0;
                     finished   = settle();
                  end else if (presence_elapsed >= cfg.presence_timeout_ticks) begin
                     phase    = owm_pkg::PH_IDLE;
                     finished = 1'b1;
                     r.fail   = 1'b1;
                  end else begin
                     presence_elapsed++;
                  end
               end
               default: begin
                  r.drive_low = (phase == owm_pkg::PH_RLOW || phase == owm_pkg::PH_WRLOW ||
                                 phase == owm_pkg::PH_RDLOW);
                  // read bit is sampled on the first tail tick
                  if (phase == owm_pkg::PH_RDTAIL && tick_count == '0)
                     shift_byte = {it.line_level, shift_byte[7:1]};
                  tick_count++;
                  finished = settle();
               end
            endcase
         end

         r.done_res = finished;
         if (finished && !r.fail && op_kind == owm_pkg::REQ_READ) r.rx_byte = shift_byte;
         if (finished) dones++;
         if (r.fail) timeouts++;
         line_outcomes.push_back(r);
      endfunction

      // Compare one result transaction with the oldest outcome due
      function void check_outcome(owm_pkg::rsp_item_type got);
         owm_pkg::rsp_item_type want;
         if (line_outcomes.size() == 0) begin
            $error("result with no tick pending: %p", got);
            mismatches++;
            return;
         end
         want = line_outcomes.pop_front();
         if (got.drive_low !== want.drive_low) begin
            $error("drive_low expected %0b got %0b", want.drive_low, got.drive_low);
            mismatches++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res expected %0b got %0b", want.busy_res, got.busy_res);
            mismatches++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res expected %0b got %0b", want.done_res, got.done_res);
            mismatches++;
         end
         if (got.fail !== want.fail) begin
            $error("fail expected %0b got %0b", want.fail, got.fail);
            mismatches++;
         end
         if (got.rx_byte !== want.rx_byte) begin
            $error("rx_byte expected %02h got %02h", want.rx_byte, got.rx_byte);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   owm_pkg::req_item_type         req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   owm_pkg::rsp_item_type         rsp_data;
   logic                          csr_we = 1'b0;
   logic [owm_pkg::CSR_IW-1:0]    csr_index = '0;
   logic [owm_pkg::CSR_W-1:0]     csr_wdata = '0;

   owm_scoreboard                 sb = new;
   fault_type                     fault_kind = FAULT_NONE;
   int unsigned                   ops_started = 0;
   int unsigned                   settings_applied = 0;
   int unsigned                   send_idle_pct = 0;
   int unsigned                   rsp_stall_pct = 0;
   bit                            holdoff_req = 1'b0;
   int unsigned                   quiet_cycles = 0;
   logic [owm_pkg::CSR_W-1:0]     setting_words [8];

   onewire_bus_master #(.RELEASE_TICKS(RELEASE_TICKS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Next tick, with the line acting like a slave for the predicted phase
   function automatic owm_pkg::req_item_type make_tick(bit may_start);
      owm_pkg::req_item_type it;
      it.req_type   = owm_pkg::REQ_TICK;
      it.tx_byte    = 8'($urandom_range(255));
      it.line_level = 1'($urandom_range(1));
      case (sb.phase)
         owm_pkg::PH_IDLE: begin
            if (may_start && $urandom_range(99) < 85) begin
               it.req_type = 2'($urandom_range(3, 1));
               fault_kind  = FAULT_NONE;
               if (sb.cfg.presence_timeout_ticks <= 1000 && $urandom_range(4) == 0)
                  fault_kind = fault_type'($urandom_range(2, 1));
               ops_started++;
            end
         end
         owm_pkg::PH_WLOWP:
            it.line_level = (fault_kind == FAULT_NO_PRESENCE) || ($urandom_range(7) != 0);
         owm_pkg::PH_WHIGHP:
            it.line_level = (fault_kind != FAULT_STUCK_LOW) && ($urandom_range(3) == 0);
         default: begin
            // a command while busy must be ignored
            if ($urandom_range(19) == 0) it.req_type = 2'($urandom_range(3, 1));
         end
      endcase
      return it;
   endfunction

   // One input transaction, then idle cycles at the sender's idle rate
   task automatic send_tick(owm_pkg::req_item_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Start one command from idle and tick until it finishes
   task automatic run_op(logic [1:0] kind, logic [7:0] data, fault_type fault);
      owm_pkg::req_item_type it;
      it.req_type   = kind;
      it.tx_byte    = data;
      it.line_level = 1'($urandom_range(1));
      fault_kind    = fault;
      ops_started++;
      send_tick(it);
      while (sb.phase != owm_pkg::PH_IDLE) send_tick(make_tick(1'b0));
   endtask

   // Finish the running operation and let every result drain out
   task automatic drain_to_idle();
      while (sb.phase != owm_pkg::PH_IDLE) send_tick(make_tick(1'b0));
      req_valid <= 1'b0;
      while (sb.line_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // One register write; the caller drops csr_we after the last one
   task automatic write_csr(logic [owm_pkg::CSR_IW-1:0] idx,
                            logic [owm_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Write all timing registers from setting_words, then pick the idling mode
   task automatic apply_setting();
      logic [owm_pkg::CSR_IW-1:0] idx;
      drain_to_idle();
      for (int i = owm_pkg::CSR_RESET_LOW; i <= owm_pkg::CSR_PRESENCE_TMO; i++) begin
         idx = i[owm_pkg::CSR_IW-1:0];
         write_csr(idx, setting_words[i]);
      end
      csr_we <= 1'b0;
      settings_applied++;
      case (settings_applied % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 45; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 45; end
         default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
      endcase
   endtask

   // Receiver: random stalls plus one long hold-off on request
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            hold_left   = HOLDOFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_outcome(rsp_data);
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("onewire_bus_master test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned v;
      int unsigned target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Short reset pulse and slots; the other registers keep their reset values
      write_csr(owm_pkg::CSR_RESET_LOW, 16'd12);
      write_csr(owm_pkg::CSR_WRITE_ZERO_LOW, 16'd3);
      write_csr(owm_pkg::CSR_SLOT, 16'd4);
      csr_we <= 1'b0;
      run_op(owm_pkg::REQ_RESET, 8'h00, FAULT_NONE);
      send_tick('{req_type: owm_pkg::REQ_TICK, tx_byte: 8'hC3, line_level: 1'b0});
      run_op(owm_pkg::REQ_WRITE, 8'hA5, FAULT_NONE);
      run_op(owm_pkg::REQ_READ, 8'h00, FAULT_NONE);

      // Minimum legal values; a write-one release saturates to nothing
      setting_words = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1};
      apply_setting();
      run_op(owm_pkg::REQ_RESET, 8'h00, FAULT_NONE);
      run_op(owm_pkg::REQ_RESET, 8'h00, FAULT_NO_PRESENCE);
      run_op(owm_pkg::REQ_WRITE, 8'h5A, FAULT_NONE);
      run_op(owm_pkg::REQ_WRITE, 8'hFF, FAULT_NONE);
      run_op(owm_pkg::REQ_READ, 8'h00, FAULT_NONE);

      // All zero: writes finish on their first tick, read tail stays one tick
      setting_words = '{default: 16'd0};
      apply_setting();
      run_op(owm_pkg::REQ_WRITE, 8'h00, FAULT_NONE);
      run_op(owm_pkg::REQ_WRITE, 8'hFF, FAULT_NONE);
      run_op(owm_pkg::REQ_READ, 8'h00, FAULT_NONE);
      run_op(owm_pkg::REQ_RESET, 8'h00, FAULT_NONE);

      // Random short timings, upper data bits junk to check masking
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = owm_pkg::CSR_RESET_LOW; i <= owm_pkg::CSR_PRESENCE_TMO; i++) begin
            v = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(12);
            if (i == owm_pkg::CSR_PRESENCE_TMO)
               v = $urandom_range(1) ? $urandom_range(3) : $urandom_range(12, 4);
            else if (i == owm_pkg::CSR_RESET_LOW)
               v |= $urandom() & 32'h0000_FC00;
            else
               v |= $urandom() & 32'h0000_FF00;
            setting_words[i] = v[15:0];
         end
         apply_setting();
         // first random phase: long receiver hold-off while ticks keep coming
         if (p == 0) holdoff_req = 1'b1;
         target = sb.ticks_noted + TICKS_PER_PHASE;
         while (sb.ticks_noted < target) send_tick(make_tick(1'b1));
      end

      drain_to_idle();
      repeat (10) @(posedge clock);

      if (sb.line_outcomes.size() != 0)
         $error("%0d results never arrived", sb.line_outcomes.size());
      $display("Ran %0d bus operations over %0d ticks: %0d completed, %0d presence timeouts",
               ops_started, sb.ticks_noted, sb.dones, sb.timeouts);
      $display("Covered reset values, %0d register sets incl. minimum and all-zero, %s",
               settings_applied, "four idling mixes and one long result stall");
      if (sb.mismatches == 0 && sb.line_outcomes.size() == 0) begin
         $display("onewire_bus_master test passed");
      end else begin
         $display("onewire_bus_master test failed");
      end
      $finish;
   end

endmodule

@@ onewire_bus_master.f @@
+incdir+design
design/owm_pkg.sv
design/onewire_bus_master.sv
tb/sv/onewire_bus_master_tb.sv
